### rtl/tit_pkg.sv
// shared types and codes for the trusted id table
package tit_pkg;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } tit_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } tit_status_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } tit_ctrl_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } tit_stat_t;

endpackage

### rtl/tit_if.sv
// request and response channel interfaces of the trusted id table
interface tit_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        pid;
  logic signed [63:0] creation_time;
  logic               process_found;

  modport source (output valid, command, pid, creation_time, process_found, input ready);
  modport sink   (input valid, command, pid, creation_time, process_found, output ready);
endinterface

interface tit_rsp_if;
  logic       valid;
  logic       ready;
  logic       trusted;
  logic [1:0] status;

  modport source (output valid, trusted, status, input ready);
  modport sink   (input valid, trusted, status, output ready);
endinterface

### rtl/tit_ctrl.sv
// sequencer for the table walk of one item
module tit_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tit_pkg::tit_stat_t stat_i,
  output tit_pkg::tit_ctrl_t ctrl_o
);
  import tit_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (stat_i.last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!stat_i.out_busy) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    ctrl_o.load   = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.step   = (state_q == S_SCAN);
    ctrl_o.commit = (state_q == S_COMMIT) && !stat_i.out_busy;
  end

endmodule

### rtl/tit_dp.sv
// slot memory, match trackers and result register
module tit_dp #(
  parameter int unsigned TableDepth = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tit_pkg::tit_ctrl_t ctrl_i,
  output tit_pkg::tit_stat_t stat_o,
  input  logic [1:0]         command_i,
  input  logic [31:0]        pid_i,
  input  logic signed [63:0] creation_time_i,
  input  logic               process_found_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               trusted_o,
  output logic [1:0]         status_o
);
  import tit_pkg::*;

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(TableDepth - 1);

  logic [31:0] id_mem   [TableDepth];
  logic [63:0] time_mem [TableDepth];
  logic [TableDepth-1:0] valid_q;

  logic [1:0]    cmd_q;
  logic [31:0]   pid_q;
  logic [63:0]   time_q;
  logic          found_q;
  logic [AW-1:0] addr_q;

  logic          rd_vld_q;
  logic          rd_ok_q;
  logic [31:0]   rd_id_q;
  logic [63:0]   rd_time_q;
  logic [AW-1:0] rd_idx_q;

  logic          hit_q;
  logic [AW-1:0] hit_idx_q;
  logic          trust_q;
  logic          free_q;
  logic [AW-1:0] free_idx_q;

  logic          out_valid_q;
  logic          trusted_q;
  logic [1:0]    status_q;

  logic [31:0] eff_id;
  logic [63:0] eff_time;
  logic        id_eq;
  logic        tm_eq;
  logic        hit_now;
  logic        free_now;
  logic        wr_en;
  logic        clr_en;
  logic        res_trusted;
  logic [1:0]  res_status;

  always_comb begin
    eff_id   = rd_ok_q ? rd_id_q : '0;
    eff_time = rd_ok_q ? rd_time_q : '0;
    id_eq    = (eff_id == pid_q);
    tm_eq    = (eff_time == time_q);
    hit_now  = (cmd_q == CMD_REMOVE) ? (id_eq && tm_eq) : id_eq;
    free_now = (eff_id == '0);
  end

  always_comb begin
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    res_trusted = 1'b0;
    res_status  = ST_NOMATCH;
    case (cmd_q)
      CMD_QUERY: begin
        if (pid_q != '0 && hit_q) begin
          res_status  = ST_DONE;
          res_trusted = trust_q;
        end
      end
      CMD_ADD: begin
        if (pid_q == '0 || hit_q) begin
          res_status = ST_PRESENT;
        end else if (free_q) begin
          res_status = ST_DONE;
          wr_en      = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (pid_q != '0 && hit_q) begin
          res_status = ST_DONE;
          clr_en     = 1'b1;
        end
      end
      default: begin
        res_status = ST_NOMATCH;
      end
    endcase
  end

  // payload side: memory, item fields, read data, tracker indexes and result fields
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= command_i;
      pid_q   <= pid_i;
      time_q  <= creation_time_i;
      found_q <= process_found_i;
    end
    if (ctrl_i.step) begin
      rd_id_q   <= id_mem[addr_q];
      rd_time_q <= time_mem[addr_q];
      rd_idx_q  <= addr_q;
    end
    if (rd_vld_q && hit_now && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      trust_q   <= found_q && tm_eq;
    end
    if (rd_vld_q && free_now && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (ctrl_i.commit && wr_en) begin
      id_mem[free_idx_q]   <= pid_q;
      time_mem[free_idx_q] <= time_q;
    end
    if (ctrl_i.commit) begin
      trusted_q <= res_trusted;
      status_q  <= res_status;
    end
  end

  // control side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_ok_q     <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.step;
      if (ctrl_i.load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (ctrl_i.step) begin
          addr_q  <= addr_q + 1'b1;
          rd_ok_q <= valid_q[addr_q];
        end
        if (rd_vld_q && hit_now) hit_q <= 1'b1;
        if (rd_vld_q && free_now) free_q <= 1'b1;
      end
      if (ctrl_i.commit && wr_en) valid_q[free_idx_q] <= 1'b1;
      if (ctrl_i.commit && clr_en) valid_q[hit_idx_q] <= 1'b0;
      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.last     = (addr_q == LastIdx);
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign trusted_o   = trusted_q;
  assign status_o    = status_q;

endmodule

### rtl/trusted_id_table.sv
// top level of the trusted process id table
// the walk reads one slot per cycle over the single read port of the slot memory
// a new item is taken while the previous result still waits in the output register
// reset: asynchronous, clears all slot valid bits so the table starts empty at once
module trusted_id_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tit_req_if.sink   req_i,
  tit_rsp_if.source rsp_o
);
  import tit_pkg::*;

  tit_ctrl_t ctrl;
  tit_stat_t stat;

  tit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tit_dp #(
    .TableDepth (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (req_i.command),
    .pid_i           (req_i.pid),
    .creation_time_i (req_i.creation_time),
    .process_found_i (req_i.process_found),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .trusted_o       (rsp_o.trusted),
    .status_o        (rsp_o.status)
  );

endmodule

### rtl/tit_checker.sv
// port-level assertions for the trusted id table and their bind
module tit_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_trusted_i,
  input logic [1:0] rsp_status_i
);
  import tit_pkg::*;

  // trusted only comes with a found entry
  a_trusted_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_trusted_i |-> rsp_status_i == ST_DONE)
    else $error("trusted result without done status");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("item taken while another is in the walk");

  // a new result only comes out of a walk
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result appeared without an item in the walk");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_trusted_i) && $stable(rsp_status_i))
    else $error("stalled result changed");

endmodule

bind trusted_id_table tit_checker u_tit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_trusted_i (rsp_o.trusted),
  .rsp_status_i  (rsp_o.status)
);
